[design/feedforward_diffuser_hicut_top_assert.svh]
// Assertion macros used by the diffuser sequencer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FEEDFORWARD_DIFFUSER_HICUT_TOP_ASSERT_SVH
`define FEEDFORWARD_DIFFUSER_HICUT_TOP_ASSERT_SVH

// Same-cycle implication.
`define FFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ffd_pkg.sv]
package ffd_pkg;

	localparam int SAMPLE_RATE_HZ = 48000;
	localparam int STAGE_COUNT    = 3;
	localparam int MAX_STAGES     = 3;
	localparam int LINE_COUNT     = 4;
	localparam int SAMPLE_W       = 24;
	localparam int GAIN_W         = 16;

	localparam int NUM_RINGS = STAGE_COUNT * LINE_COUNT;
	localparam int RING_MAX  = (1150 * SAMPLE_RATE_HZ + 50000) / 100000 + 2;
	localparam int POS_W     = $clog2(RING_MAX);
	localparam int RING_W    = $clog2(NUM_RINGS);
	localparam int STAGE_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int LINE_W    = $clog2(LINE_COUNT);

	typedef int unsigned ring_tab_t [MAX_STAGES * LINE_COUNT];

	// Line delays in hundredths of a millisecond, stage by stage.
	localparam ring_tab_t DLY_CENTI = '{
		33, 102, 169, 231,
		384, 558, 603, 646,
		626, 659, 1139, 1150
	};

	function automatic ring_tab_t calc_dly();
		ring_tab_t t;
		longint unsigned dl;
		t = '{default: 0};
		for (int i = 0; i < NUM_RINGS; i++) begin
			dl = (longint'(DLY_CENTI[i]) * SAMPLE_RATE_HZ + 50000) / 100000;
			if (dl < 1)
				dl = 1;
			if (dl > RING_MAX - 1)
				dl = RING_MAX - 1;
			t[i] = int'(dl);
		end
		return t;
	endfunction

	// Delay of each ring; the ring itself holds one entry more.
	localparam ring_tab_t RING_DLY = calc_dly();

	function automatic ring_tab_t calc_base();
		ring_tab_t t;
		t = '{default: 0};
		for (int i = 1; i < NUM_RINGS; i++)
			t[i] = t[i-1] + RING_DLY[i-1] + 1;
		return t;
	endfunction

	function automatic int calc_span();
		int s;
		s = 0;
		for (int i = 0; i < NUM_RINGS; i++)
			s = s + int'(RING_DLY[i]) + 1;
		return s;
	endfunction

	function automatic int calc_dly_max();
		int m;
		m = 0;
		for (int i = 0; i < NUM_RINGS; i++)
			if (int'(RING_DLY[i]) > m)
				m = int'(RING_DLY[i]);
		return m;
	endfunction

	localparam ring_tab_t RING_BASE = calc_base();
	localparam int CH_SPAN    = calc_span();
	localparam int RING_DEPTH = 2 * CH_SPAN;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int DLY_MAX    = calc_dly_max();

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_S1_WET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_S1_DRY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_S2_WET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_S2_DRY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_S3_WET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_S3_DRY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POLE   = 3'd6;

	localparam logic [GAIN_W:0] GAIN_ONE = {1'b1, {GAIN_W{1'b0}}};

	typedef logic signed [SAMPLE_W-1:0] smp_t;
	typedef logic [GAIN_W:0] gain_t;

	typedef struct packed {
		gain_t [MAX_STAGES-1:0] wet;
		gain_t [MAX_STAGES-1:0] dry;
		logic [GAIN_W-1:0]      pole;
	} ffd_cfg_t;

	typedef struct packed {
		logic              load_left;
		logic              load_right;
		logic [LINE_W-1:0] line;
		logic              cap;
		logic [LINE_W-1:0] cap_line;
		logic              cap_zero;
		logic              bfly;
		logic              mul;
		logic              sum;
		logic              hmul;
		logic              hsum;
		logic              out_load;
		logic              ch;
		logic [STAGE_W-1:0] stage;
	} ffd_ctl_t;

endpackage

[design/feedforward_diffuser_hicut_top.sv]
// Channel  Handshake              Beat contents
// -------  ---------------------  ----------------------------------------------
// cfg      cfg_valid / cfg_ready  cfg_index (register 0..6), cfg_data (17 bits)
// in       in_valid / in_ready    left_sample, right_sample (Q1.23)
// out      out_valid / out_ready  left_out, right_out (Q1.23, saturated)
//
// For each stereo beat, each channel in turn runs three stages (four ring
// accesses on the single ring memory, butterfly, multiply, sum) and then the
// hi-cut multiply and sum.
// Reset clears control, config and hi-cut registers at once; ring contents are
// masked by a fill count, so no clearing pass is needed before input is taken.
// A finished result waits in the output register while the next beat runs;
// only the final load stalls, and only if that register is still full.
// Configuration beats are taken in any cycle and should arrive while idle.
module feedforward_diffuser_hicut_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ffd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ffd_pkg::smp_t                  left_sample,
	input  ffd_pkg::smp_t                  right_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ffd_pkg::smp_t                  left_out,
	output ffd_pkg::smp_t                  right_out
);
	import ffd_pkg::*;

	ffd_cfg_t          cfg_q;
	ffd_ctl_t          ctl;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	smp_t              ram_wdata;
	smp_t              ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wet  <= '0;
			cfg_q.pole <= '0;
			for (int i = 0; i < MAX_STAGES; i++)
				cfg_q.dry[i] <= GAIN_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_S1_WET: cfg_q.wet[0] <= cfg_data;
				REG_S1_DRY: cfg_q.dry[0] <= cfg_data;
				REG_S2_WET: cfg_q.wet[1] <= cfg_data;
				REG_S2_DRY: cfg_q.dry[1] <= cfg_data;
				REG_S3_WET: cfg_q.wet[2] <= cfg_data;
				REG_S3_DRY: cfg_q.dry[2] <= cfg_data;
				REG_POLE:   cfg_q.pole   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	ffd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	ffd_ring_ram u_ring_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ffd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg_q),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.rdata        (ram_rdata),
		.wdata        (ram_wdata),
		.left_out     (left_out),
		.right_out    (right_out)
	);

endmodule

[design/ffd_ring_ram.sv]
module ffd_ring_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ffd_pkg::ADDR_W-1:0] waddr,
	input  ffd_pkg::smp_t             wdata,
	input  logic [ffd_pkg::ADDR_W-1:0] raddr,
	output ffd_pkg::smp_t             rdata
);
	import ffd_pkg::*;

	// All delay rings of both channels, packed one after another.
	logic [SAMPLE_W-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[design/ffd_seq.sv]
`include "feedforward_diffuser_hicut_top_assert.svh"

module ffd_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ffd_pkg::ffd_ctl_t          ctl,
	output logic                       ram_we,
	output logic [ffd_pkg::ADDR_W-1:0] ram_waddr,
	output logic [ffd_pkg::ADDR_W-1:0] ram_raddr
);
	import ffd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RW   = 3'd1;
	localparam logic [2:0] S_BFLY = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_HMUL = 3'd5;
	localparam logic [2:0] S_HSUM = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]         state_q;
	logic               ch_q;
	logic [STAGE_W-1:0] stage_q;
	logic [LINE_W-1:0]  line_q;
	logic [POS_W-1:0]   pos_q [NUM_RINGS];
	logic [POS_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               cap_s1;
	logic [LINE_W-1:0]  cap_line_s1;
	logic               cap_zero_s1;

	logic [RING_W-1:0]  ring_cur;
	logic [POS_W-1:0]   pos_cur;
	logic [POS_W-1:0]   dly_cur;
	logic [POS_W-1:0]   rd_cur;
	logic [ADDR_W-1:0]  base_cur;
	logic               last_stage;
	logic               out_free;

	assign ring_cur   = RING_W'(int'(stage_q) * LINE_COUNT + int'(line_q));
	assign pos_cur    = pos_q[ring_cur];
	assign dly_cur    = POS_W'(RING_DLY[ring_cur]);
	assign rd_cur     = (pos_cur == dly_cur) ? '0 : pos_cur + 1'b1;
	assign base_cur   = ADDR_W'(RING_BASE[ring_cur]) + (ch_q ? ADDR_W'(CH_SPAN) : '0);
	assign last_stage = (stage_q == STAGE_W'(STAGE_COUNT - 1));
	assign out_free   = !out_valid_q || out_ready;

	assign ram_we    = (state_q == S_RW);
	assign ram_waddr = base_cur + ADDR_W'(pos_cur);
	assign ram_raddr = base_cur + ADDR_W'(rd_cur);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl.load_left  = (state_q == S_IDLE) && in_valid;
		ctl.load_right = (state_q == S_HSUM) && !ch_q;
		ctl.line       = line_q;
		ctl.cap        = cap_s1;
		ctl.cap_line   = cap_line_s1;
		ctl.cap_zero   = cap_zero_s1;
		ctl.bfly       = (state_q == S_BFLY);
		ctl.mul        = (state_q == S_MUL);
		ctl.sum        = (state_q == S_SUM);
		ctl.hmul       = (state_q == S_HMUL);
		ctl.hsum       = (state_q == S_HSUM);
		ctl.out_load   = (state_q == S_DONE) && out_free;
		ctl.ch         = ch_q;
		ctl.stage      = stage_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			stage_q     <= '0;
			line_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			cap_s1      <= 1'b0;
			cap_line_s1 <= '0;
			cap_zero_s1 <= 1'b0;
			for (int i = 0; i < NUM_RINGS; i++)
				pos_q[i] <= '0;
		end else begin
			// Read data lands the cycle after the address, so the capture
			// information trails the ring access by one stage.
			cap_s1      <= (state_q == S_RW);
			cap_line_s1 <= line_q;
			// A ring entry not yet written since reset reads as zero.
			cap_zero_s1 <= (cnt_q < dly_cur);

			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= 1'b0;
						stage_q <= '0;
						line_q  <= '0;
						state_q <= S_RW;
					end
				end
				S_RW: begin
					line_q <= line_q + 1'b1;
					if (line_q == LINE_W'(LINE_COUNT - 1))
						state_q <= S_BFLY;
				end
				S_BFLY: state_q <= S_MUL;
				S_MUL:  state_q <= S_SUM;
				S_SUM: begin
					if (last_stage) begin
						state_q <= S_HMUL;
					end else begin
						stage_q <= stage_q + 1'b1;
						state_q <= S_RW;
					end
				end
				S_HMUL: state_q <= S_HSUM;
				S_HSUM: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						stage_q <= '0;
						line_q  <= '0;
						state_q <= S_RW;
					end else begin
						// Both channels share ring positions, so they move on
						// once the right channel is through.
						for (int i = 0; i < NUM_RINGS; i++)
							pos_q[i] <= (pos_q[i] == POS_W'(RING_DLY[i])) ? '0
								: pos_q[i] + 1'b1;
						if (cnt_q != POS_W'(DLY_MAX))
							cnt_q <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FFD_ASSERT_NOW(a_ring_ports_apart, ram_we, ram_waddr != ram_raddr, "ring write and read hit one entry")
	`FFD_ASSERT_NOW(a_pos_in_ring, state_q == S_RW, pos_cur <= dly_cur, "ring position beyond its ring")
	`FFD_ASSERT_NOW(a_fill_steps, cnt_q != $past(cnt_q), cnt_q == $past(cnt_q) + 1'b1, "fill count jumped")
	`FFD_ASSERT_NEXT(a_right_then_done, state_q == S_HSUM && ch_q, state_q == S_DONE, "sample did not finish after right channel")

endmodule

[design/ffd_dpath.sv]
module ffd_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  ffd_pkg::ffd_ctl_t ctl,
	input  ffd_pkg::ffd_cfg_t cfg,
	input  ffd_pkg::smp_t     left_sample,
	input  ffd_pkg::smp_t     right_sample,
	input  ffd_pkg::smp_t     rdata,
	output ffd_pkg::smp_t     wdata,
	output ffd_pkg::smp_t     left_out,
	output ffd_pkg::smp_t     right_out
);
	import ffd_pkg::*;

	localparam int OP_W   = SAMPLE_W + 1;
	localparam int GOP_W  = GAIN_W + 2;
	localparam int PROD_W = GOP_W + OP_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int SHR_W  = SUM_W - GAIN_W;

	localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [SUM_W-1:0]    RND_HALF =
		{{(SUM_W-GAIN_W){1'b0}}, 1'b1, {(GAIN_W-1){1'b0}}};

	function automatic smp_t sat_wide(input logic [SHR_W-1:0] x);
		smp_t r;
		if (x[SHR_W-1:SAMPLE_W-1] == '0 || x[SHR_W-1:SAMPLE_W-1] == '1)
			r = x[SAMPLE_W-1:0];
		else
			r = x[SHR_W-1] ? SMP_MIN : SMP_MAX;
		return r;
	endfunction

	function automatic smp_t halve(input smp_t x);
		logic [SAMPLE_W:0] t;
		t = {x[SAMPLE_W-1], x} + 1'b1;
		return t[SAMPLE_W:1];
	endfunction

	// (p + q) / 2^GAIN_W rounded half up, then saturated.
	function automatic smp_t mix_round(input logic signed [PROD_W-1:0] p,
		input logic signed [PROD_W-1:0] q);
		logic [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(q) + RND_HALF;
		return sat_wide(s[SUM_W-1:GAIN_W]);
	endfunction

	smp_t                     in_right_q;
	smp_t                     v_q [LINE_COUNT];
	smp_t                     d_q [LINE_COUNT];
	logic signed [OP_W-1:0]   h_q [LINE_COUNT];
	logic signed [PROD_W-1:0] p_q [LINE_COUNT];
	logic signed [PROD_W-1:0] q_q [LINE_COUNT];
	smp_t                     lp_q [2];
	smp_t                     left_out_q;
	smp_t                     right_out_q;

	smp_t                     rd_eff;
	smp_t                     dsel [LINE_COUNT];
	logic [SAMPLE_W:0]        a0, a1, a2, a3;
	logic [SAMPLE_W+1:0]      b [LINE_COUNT];
	logic signed [OP_W-1:0]   h_next [LINE_COUNT];
	logic [SAMPLE_W:0]        twice;
	smp_t                     diffused;
	logic [GAIN_W:0]          one_minus_pole;
	logic signed [GOP_W-1:0]  ga [LINE_COUNT];
	logic signed [OP_W-1:0]   sa [LINE_COUNT];
	logic signed [GOP_W-1:0]  gb [LINE_COUNT];
	logic signed [OP_W-1:0]   sb [LINE_COUNT];
	smp_t                     entry_src;
	smp_t                     half;
	smp_t                     y;

	assign wdata     = v_q[ctl.line];
	assign rd_eff    = ctl.cap_zero ? '0 : rdata;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// The last line's read data is used straight from the memory port.
	always_comb begin
		for (int l = 0; l < LINE_COUNT; l++)
			dsel[l] = (ctl.cap && ctl.cap_line == LINE_W'(l)) ? rd_eff : d_q[l];
	end

	always_comb begin
		a0 = {dsel[0][SAMPLE_W-1], dsel[0]} + {dsel[1][SAMPLE_W-1], dsel[1]};
		a1 = {dsel[0][SAMPLE_W-1], dsel[0]} - {dsel[1][SAMPLE_W-1], dsel[1]};
		a2 = {dsel[2][SAMPLE_W-1], dsel[2]} + {dsel[3][SAMPLE_W-1], dsel[3]};
		a3 = {dsel[2][SAMPLE_W-1], dsel[2]} - {dsel[3][SAMPLE_W-1], dsel[3]};
		b[0] = {a0[SAMPLE_W], a0} + {a2[SAMPLE_W], a2} + 1'b1;
		b[1] = {a1[SAMPLE_W], a1} + {a3[SAMPLE_W], a3} + 1'b1;
		b[2] = {a0[SAMPLE_W], a0} - {a2[SAMPLE_W], a2} + 1'b1;
		b[3] = {a1[SAMPLE_W], a1} - {a3[SAMPLE_W], a3} + 1'b1;
		for (int l = 0; l < LINE_COUNT; l++)
			h_next[l] = b[l][SAMPLE_W+1:1];
	end

	always_comb begin
		twice = {v_q[0], 1'b0};
		if (twice[SAMPLE_W] != twice[SAMPLE_W-1])
			diffused = twice[SAMPLE_W] ? SMP_MIN : SMP_MAX;
		else
			diffused = twice[SAMPLE_W-1:0];
		one_minus_pole = GAIN_ONE - {1'b0, cfg.pole};
	end

	// Lane 0's multipliers also serve the hi-cut filter.
	always_comb begin
		for (int l = 0; l < LINE_COUNT; l++) begin
			ga[l] = {1'b0, cfg.dry[ctl.stage]};
			sa[l] = {v_q[l][SAMPLE_W-1], v_q[l]};
			gb[l] = {1'b0, cfg.wet[ctl.stage]};
			sb[l] = h_q[l];
		end
		if (ctl.hmul) begin
			ga[0] = {1'b0, one_minus_pole};
			sa[0] = {diffused[SAMPLE_W-1], diffused};
			gb[0] = {2'b00, cfg.pole};
			sb[0] = {lp_q[ctl.ch][SAMPLE_W-1], lp_q[ctl.ch]};
		end
	end

	assign entry_src = ctl.load_left ? left_sample : in_right_q;
	assign half      = halve(entry_src);
	assign y         = mix_round(p_q[0], q_q[0]);

	always_ff @(posedge clk) begin
		if (ctl.load_left)
			in_right_q <= right_sample;

		if (ctl.load_left || ctl.load_right) begin
			v_q[0] <= half;
			v_q[1] <= half;
			v_q[2] <= half;
			v_q[3] <= -half;
		end else if (ctl.sum) begin
			for (int l = 0; l < LINE_COUNT; l++)
				v_q[l] <= mix_round(p_q[l], q_q[l]);
		end

		if (ctl.cap)
			d_q[ctl.cap_line] <= rd_eff;

		if (ctl.bfly)
			h_q <= h_next;

		if (ctl.mul || ctl.hmul) begin
			for (int l = 0; l < LINE_COUNT; l++) begin
				p_q[l] <= ga[l] * sa[l];
				q_q[l] <= gb[l] * sb[l];
			end
		end

		if (ctl.out_load) begin
			left_out_q  <= lp_q[0];
			right_out_q <= lp_q[1];
		end
	end

	// The hi-cut memories are part of the filter state and clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q[0] <= '0;
			lp_q[1] <= '0;
		end else if (ctl.hsum) begin
			lp_q[ctl.ch] <= y;
		end
	end

endmodule
